/* rtl/owm_pkg.sv */
// owm_pkg: shared constants and codes for the 1-wire bus master
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package owm_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int NUM_REGS      = 8;
	localparam int TICK_W        = 16;
	localparam int REG_IDX_W     = 3;
	localparam int BIT_IDX_W     = 4;
	localparam int KIND_W        = 2;

	typedef logic [KIND_W-1:0]        kind_t;
	typedef logic [BITS_PER_BYTE-1:0] byte_t;
	typedef logic [TICK_W-1:0]        tick_t;
	typedef logic [REG_IDX_W-1:0]     reg_idx_t;

	// command codes
	localparam kind_t KIND_TICK  = 2'd0;
	localparam kind_t KIND_RESET = 2'd1;
	localparam kind_t KIND_WRITE = 2'd2;
	localparam kind_t KIND_READ  = 2'd3;

	// timing register indexes
	localparam reg_idx_t REG_RST_LOW     = 3'd0;
	localparam reg_idx_t REG_PRES_SAMPLE = 3'd1;
	localparam reg_idx_t REG_RST_REC     = 3'd2;
	localparam reg_idx_t REG_W1_LOW      = 3'd3;
	localparam reg_idx_t REG_W0_LOW      = 3'd4;
	localparam reg_idx_t REG_RD_LOW      = 3'd5;
	localparam reg_idx_t REG_RD_SAMPLE   = 3'd6;
	localparam reg_idx_t REG_SLOT        = 3'd7;

	// timing register reset values
	localparam tick_t DEF_RST_LOW     = 16'd3812;
	localparam tick_t DEF_PRES_SAMPLE = 16'd568;
	localparam tick_t DEF_RST_REC     = 16'd3329;
	localparam tick_t DEF_W1_LOW      = 16'd40;
	localparam tick_t DEF_W0_LOW      = 16'd470;
	localparam tick_t DEF_RD_LOW      = 16'd44;
	localparam tick_t DEF_RD_SAMPLE   = 16'd70;
	localparam tick_t DEF_SLOT        = 16'd540;

endpackage

`default_nettype wire

/* rtl/owm_cmd_if.sv */
// owm_cmd_if: command channel (one bus tick per item) with valid/ready
// depends on owm_pkg
`default_nettype none

interface owm_cmd_if;
	import owm_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	byte_t data;
	logic  line_in;

	modport source (output valid, output kind, output data, output line_in, input ready);
	modport sink   (input valid, input kind, input data, input line_in, output ready);
endinterface

`default_nettype wire

/* rtl/owm_res_if.sv */
// owm_res_if: result channel (bus drive and status per tick) with valid/ready
// depends on owm_pkg
`default_nettype none

interface owm_res_if;
	import owm_pkg::*;

	logic  valid;
	logic  ready;
	logic  drive_low;
	logic  busy_res;
	logic  done_res;
	byte_t read_data;
	logic  presence;
	logic  rejected;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output read_data, output presence, output rejected, input ready);
	modport sink   (input valid, input drive_low, input busy_res, input done_res,
		input read_data, input presence, input rejected, output ready);
endinterface

`default_nettype wire

/* rtl/one_wire_bus_master_unit.sv */
// one_wire_bus_master_unit: 1-wire bus master sequencer, one bus tick per item
// depends on owm_pkg, owm_cmd_if, owm_res_if
`default_nettype none

// Every item on the cmd channel is one bus tick: it carries the sampled line
// level and optionally a command (reset with presence detect, byte write sent
// lsb first, byte read shifted in at bit 7). One item is taken per clock while
// cmd.ready is high; its result (drive_low and status) is registered when the
// item is taken. The only thing that holds off cmd.ready is an untaken result
// in the output register, so an always-ready sink sees one result per clock.
// Commands are taken only while idle; a command seen while busy (including on
// the done tick) is dropped and flagged with rejected. Bit and reset timing is
// set by the eight 16-bit timing registers on the cfg port, which must only be
// written while no command is running.
module one_wire_bus_master_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	owm_cmd_if.sink                cmd,
	owm_res_if.source              res,
	input  wire logic              cfg_we,
	input  wire owm_pkg::reg_idx_t cfg_index,
	input  wire owm_pkg::tick_t    cfg_data
);
	import owm_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RST_LOW,
		PH_RST_WAIT,
		PH_RST_REC,
		PH_WRITE,
		PH_READ
	} phase_t;

	// timing registers
	tick_t rst_low_q, pres_sample_q, rst_rec_q, w1_low_q, w0_low_q;
	tick_t rd_low_q, rd_sample_q, slot_q;

	// sequencer state
	phase_t                phase_q;
	tick_t                 tick_q;
	logic [BIT_IDX_W-1:0]  bit_idx_q;
	byte_t                 shift_q;
	logic                  pres_q;
	byte_t                 last_read_q;

	// output register
	logic  res_valid_q;
	logic  res_drive_q, res_busy_q, res_done_q, res_pres_q, res_rej_q;
	byte_t res_read_q;

	logic cmd_acc;

	// command start view of the state
	logic                 start;
	phase_t               phase_e;
	tick_t                tick_e;
	logic [BIT_IDX_W-1:0] bit_e;
	byte_t                shift_e;
	logic                 pres_e;

	// next state and per-tick result
	phase_t               phase_n;
	tick_t                tick_n;
	logic [BIT_IDX_W-1:0] bit_n;
	byte_t                shift_n;
	logic                 pres_n;
	byte_t                last_read_n;
	logic                 drive;
	logic                 done;
	logic                 rejected;

	// slot arithmetic
	logic [TICK_W:0] cnt_inc;
	logic [TICK_W:0] slot_len;
	logic [TICK_W:0] samp_raw;
	logic [TICK_W:0] samp_at;
	logic [TICK_W:0] low_time;
	byte_t           shift_s;

	// a finished result waiting in the output register holds off the next tick unless the sink takes it in the same cycle
	assign cmd.ready = !res_valid_q || res.ready;
	assign cmd_acc   = cmd.valid && cmd.ready;

	// timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rst_low_q     <= DEF_RST_LOW;
			pres_sample_q <= DEF_PRES_SAMPLE;
			rst_rec_q     <= DEF_RST_REC;
			w1_low_q      <= DEF_W1_LOW;
			w0_low_q      <= DEF_W0_LOW;
			rd_low_q      <= DEF_RD_LOW;
			rd_sample_q   <= DEF_RD_SAMPLE;
			slot_q        <= DEF_SLOT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RST_LOW:     rst_low_q     <= cfg_data;
				REG_PRES_SAMPLE: pres_sample_q <= cfg_data;
				REG_RST_REC:     rst_rec_q     <= cfg_data;
				REG_W1_LOW:      w1_low_q      <= cfg_data;
				REG_W0_LOW:      w0_low_q      <= cfg_data;
				REG_RD_LOW:      rd_low_q      <= cfg_data;
				REG_RD_SAMPLE:   rd_sample_q   <= cfg_data;
				REG_SLOT:        slot_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// a command on an idle tick starts right away on that same tick
	always_comb begin
		start   = (phase_q == PH_IDLE) && (cmd.kind != KIND_TICK);
		phase_e = phase_q;
		tick_e  = tick_q;
		bit_e   = bit_idx_q;
		shift_e = shift_q;
		pres_e  = pres_q;
		if (start) begin
			tick_e = '0;
			bit_e  = '0;
			case (cmd.kind)
				KIND_RESET: begin
					phase_e = PH_RST_LOW;
					pres_e  = 1'b0;
				end
				KIND_WRITE: begin
					phase_e = PH_WRITE;
					shift_e = cmd.data;
				end
				KIND_READ: begin
					phase_e = PH_READ;
					shift_e = '0;
				end
				default: ;
			endcase
		end
	end

	// a zero slot length acts as a one-tick slot; a late read sample clamps to the last tick
	assign cnt_inc  = {1'b0, tick_e} + 17'd1;
	assign slot_len = (slot_q == '0) ? 17'd1 : {1'b0, slot_q};
	assign samp_raw = {1'b0, rd_low_q} + {1'b0, rd_sample_q};
	assign samp_at  = (samp_raw > slot_len - 17'd1) ? slot_len - 17'd1 : samp_raw;
	assign low_time = (phase_e == PH_WRITE) ?
		(shift_e[0] ? {1'b0, w1_low_q} : {1'b0, w0_low_q}) : {1'b0, rd_low_q};
	assign shift_s  = ((phase_e == PH_READ) && ({1'b0, tick_e} == samp_at)) ?
		{cmd.line_in, shift_e[BITS_PER_BYTE-1:1]} : shift_e;

	// one tick of the sequencer
	always_comb begin
		phase_n     = phase_e;
		tick_n      = tick_e;
		bit_n       = bit_e;
		shift_n     = shift_e;
		pres_n      = pres_e;
		last_read_n = last_read_q;
		drive       = 1'b0;
		done        = 1'b0;
		rejected    = (phase_q != PH_IDLE) && (cmd.kind != KIND_TICK);
		case (phase_e)
			PH_RST_LOW: begin
				// held low at least one tick even with a zero low time
				drive = 1'b1;
				if (cnt_inc >= {1'b0, rst_low_q}) begin
					phase_n = PH_RST_WAIT;
					tick_n  = '0;
				end else begin
					tick_n = cnt_inc[TICK_W-1:0];
				end
			end
			PH_RST_WAIT: begin
				if (tick_e >= pres_sample_q) begin
					// a device answers by pulling the line low
					pres_n  = !cmd.line_in;
					phase_n = PH_RST_REC;
					tick_n  = '0;
				end else begin
					tick_n = cnt_inc[TICK_W-1:0];
				end
			end
			PH_RST_REC: begin
				if (tick_e >= rst_rec_q) begin
					done   = 1'b1;
					tick_n = '0;
				end else begin
					tick_n = cnt_inc[TICK_W-1:0];
				end
			end
			PH_WRITE, PH_READ: begin
				drive   = ({1'b0, tick_e} < low_time);
				shift_n = shift_s;
				if (cnt_inc >= slot_len) begin
					tick_n = '0;
					if (phase_e == PH_WRITE)
						shift_n = shift_s >> 1;
					bit_n = bit_e + 4'd1;
					if (bit_n >= BIT_IDX_W'(BITS_PER_BYTE)) begin
						done = 1'b1;
						if (phase_e == PH_READ)
							last_read_n = shift_s;
					end
				end else begin
					tick_n = cnt_inc[TICK_W-1:0];
				end
			end
			default: ;
		endcase
		if (done) begin
			phase_n = PH_IDLE;
			bit_n   = '0;
		end
	end

	// sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_idx_q   <= '0;
			shift_q     <= '0;
			pres_q      <= 1'b0;
			last_read_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_acc) begin
				phase_q     <= phase_n;
				tick_q      <= tick_n;
				bit_idx_q   <= bit_n;
				shift_q     <= shift_n;
				pres_q      <= pres_n;
				last_read_q <= last_read_n;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			res_drive_q <= drive;
			res_busy_q  <= (phase_n != PH_IDLE);
			res_done_q  <= done;
			res_read_q  <= last_read_n;
			res_pres_q  <= pres_n;
			res_rej_q   <= rejected;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.drive_low = res_drive_q;
	assign res.busy_res  = res_busy_q;
	assign res.done_res  = res_done_q;
	assign res.read_data = res_read_q;
	assign res.presence  = res_pres_q;
	assign res.rejected  = res_rej_q;

	// a completed command leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_done_q |-> !res_busy_q)
		else $error("done reported while still busy");

	// the bit counter is zero whenever the sequencer is idle
	a_idle_bit: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bit_idx_q == '0)
		else $error("bit index not cleared in idle");

	// the bit counter never passes the last bit of a byte
	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_idx_q < BIT_IDX_W'(BITS_PER_BYTE))
		else $error("bit index out of range");

	// a tick taken while idle is never rejected
	a_idle_no_rej: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && phase_q == PH_IDLE |=> !res_rej_q)
		else $error("command rejected while idle");

	// presence is cleared for the whole reset low pulse
	a_pres_clear: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_RST_LOW |-> !pres_q)
		else $error("presence set during reset pulse");

endmodule

`default_nettype wire
